// ===== hdl/ise_pkg.sv =====
package ise_pkg;
  localparam int MAX_RUNS_DEF = 64;
  localparam int ID_BITS_DEF = 32;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_CONTAINS = 2'd1;
  localparam logic [1:0] OP_RANK     = 2'd2;
  localparam logic [1:0] OP_SELECT   = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_NOTMEM = 3'd3;
  localparam logic [2:0] ST_RANGE  = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] entity;
    logic [31:0] position;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [31:0] answer;
    logic [31:0] member_total;
    logic [6:0]  run_total;
    logic [2:0]  status;
  } out_word_t;
endpackage

// ===== hdl/interval_set_engine_core.sv =====
// Each stored run scanned passes through a read state (S_RD) and a check state (S_CHK);
// a shifting insert then moves the later runs through S_SHR and S_SHW before S_DONE.
// Only one word is in flight: busy stays high through the strobe cycle, so no new word
// is taken before the result of the last one has been strobed.
// Reset (rst_n low, synchronous) empties the set; run memory contents are left as is.
// The result strobe lasts one cycle; the receiver cannot stall.
module interval_set_engine_core #(
  parameter int MAX_RUNS = ise_pkg::MAX_RUNS_DEF,
  parameter int ID_BITS  = ise_pkg::ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ise_pkg::in_word_t in_word,
  output logic              out_strobe,
  output ise_pkg::out_word_t out_word
);
  localparam int AW = $clog2(MAX_RUNS);
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_RUNS);

  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_CHK = 3'd2,
                         S_SHR = 3'd3, S_SHW = 3'd4, S_DONE = 3'd5;

  // run memory: {start, length}
  logic [2*ID_BITS-1:0] mem [MAX_RUNS];
  logic [2*ID_BITS-1:0] rdata_r;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [2*ID_BITS-1:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       rc_r, rc_nxt, idx_r, idx_nxt;
  logic [31:0]         mc_r, mc_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [ID_BITS-1:0]  e_r, e_nxt;
  logic [31:0]         pos_r, pos_nxt, acc_r, acc_nxt;
  logic                found_r, found_nxt;
  logic [31:0]         ans_r, ans_nxt;
  logic [2:0]          st_r, st_nxt;
  // previous run seen during insert scan
  logic                pv_r, pv_nxt;       // previous run exists and ends at e-1
  logic [ID_BITS-1:0]  ps_r, ps_nxt, pl_r, pl_nxt;
  logic [1:0]          mode_r, mode_nxt;   // 0 open shift-up, 1 merge shift-down
  logic [2*ID_BITS-1:0] carry_r, carry_nxt;
  logic                ostb_r, ostb_nxt;

  logic [ID_BITS-1:0] rs, rl, rlast;
  assign rs = rdata_r[2*ID_BITS-1:ID_BITS];
  assign rl = rdata_r[ID_BITS-1:0];
  assign rlast = rs + rl - 1'b1;

  always_comb begin
    state_nxt = state_r; rc_nxt = rc_r; idx_nxt = idx_r; mc_nxt = mc_r;
    op_nxt = op_r; e_nxt = e_r; pos_nxt = pos_r; acc_nxt = acc_r;
    found_nxt = found_r; ans_nxt = ans_r; st_nxt = st_r;
    pv_nxt = pv_r; ps_nxt = ps_r; pl_nxt = pl_r; mode_nxt = mode_r;
    carry_nxt = carry_r; ostb_nxt = 1'b0;
    we = 1'b0; waddr = idx_r[AW-1:0]; wdata = rdata_r;
    raddr = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        // hold off while the previous result is on the strobe
        if (start && !ostb_r) begin
          op_nxt = in_word.operation;
          e_nxt = ID_BITS'(in_word.entity);
          pos_nxt = in_word.position;
          acc_nxt = '0; idx_nxt = '0; pv_nxt = 1'b0;
          found_nxt = 1'b0; ans_nxt = '0; st_nxt = ise_pkg::ST_OK;
          raddr = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        // read of idx issued last cycle lands in rdata_r next
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (idx_r < rc_r) begin
          case (op_r)
            ise_pkg::OP_SELECT: begin
              if (pos_r < 32'(rl)) begin
                ans_nxt = 32'(rs + ID_BITS'(pos_r)); found_nxt = 1'b1;
                state_nxt = S_DONE;
              end else begin
                pos_nxt = pos_r - 32'(rl);
              end
            end
            ise_pkg::OP_RANK, ise_pkg::OP_CONTAINS: begin
              if (e_r <= rlast) begin
                if (e_r >= rs) begin
                  found_nxt = 1'b1;
                  ans_nxt = (op_r == ise_pkg::OP_RANK) ? acc_r + 32'(e_r - rs) : '0;
                end else if (op_r == ise_pkg::OP_RANK) begin
                  st_nxt = ise_pkg::ST_NOTMEM;
                end
                state_nxt = S_DONE;
              end else begin
                acc_nxt = acc_r + 32'(rl);
              end
            end
            default: begin // insert
              if (e_r >= rs && e_r <= rlast) begin
                st_nxt = ise_pkg::ST_DUP; found_nxt = 1'b1; state_nxt = S_DONE;
              end else if (e_r < rs) begin
                if (mc_r == 32'hFFFF_FFFF) begin
                  st_nxt = ise_pkg::ST_FULL; state_nxt = S_DONE;
                end else if (pv_r && e_r + 1'b1 == rs) begin
                  // bridge: previous run absorbs this one, shift rest down
                  we = 1'b1; waddr = AW'(idx_r - 1'b1);
                  wdata = {ps_r, pl_r + rl + 1'b1};
                  mode_nxt = 2'd1; idx_nxt = idx_r + 1'b1;
                  mc_nxt = mc_r + 1'b1;
                  rc_nxt = rc_r - 1'b1;
                  found_nxt = 1'b1;
                  raddr = AW'(idx_r + 1'b1);
                  state_nxt = (idx_r + 1'b1 < rc_r) ? S_SHR : S_DONE;
                end else if (pv_r) begin
                  we = 1'b1; waddr = AW'(idx_r - 1'b1);
                  wdata = {ps_r, pl_r + 1'b1};
                  mc_nxt = mc_r + 1'b1; found_nxt = 1'b1; state_nxt = S_DONE;
                end else if (e_r + 1'b1 == rs) begin
                  we = 1'b1; wdata = {e_r, rl + 1'b1};
                  mc_nxt = mc_r + 1'b1; found_nxt = 1'b1; state_nxt = S_DONE;
                end else if (rc_r >= CNT_FULL) begin
                  st_nxt = ise_pkg::ST_FULL; state_nxt = S_DONE;
                end else begin
                  // open new run here, carry old one upward
                  we = 1'b1; wdata = {e_r, ID_BITS'(1)};
                  carry_nxt = rdata_r; mode_nxt = 2'd0;
                  idx_nxt = idx_r + 1'b1; mc_nxt = mc_r + 1'b1;
                  found_nxt = 1'b1;
                  raddr = AW'(idx_r + 1'b1);
                  state_nxt = S_SHW;
                end
              end else begin
                pv_nxt = (e_r == rlast + 1'b1);
                ps_nxt = rs; pl_nxt = rl;
              end
            end
          endcase
          if (state_nxt == S_CHK) begin
            idx_nxt = idx_r + 1'b1;
            raddr = AW'(idx_r + 1'b1);
            state_nxt = S_RD;
          end
        end else begin
          // past the last run
          case (op_r)
            ise_pkg::OP_SELECT: st_nxt = ise_pkg::ST_RANGE;
            ise_pkg::OP_RANK: st_nxt = ise_pkg::ST_NOTMEM;
            ise_pkg::OP_CONTAINS: st_nxt = ise_pkg::ST_OK;
            default: begin
              if (mc_r == 32'hFFFF_FFFF) begin
                st_nxt = ise_pkg::ST_FULL;
              end else if (pv_r) begin
                we = 1'b1; waddr = AW'(idx_r - 1'b1);
                wdata = {ps_r, pl_r + 1'b1};
                mc_nxt = mc_r + 1'b1; found_nxt = 1'b1;
              end else if (rc_r >= CNT_FULL) begin
                st_nxt = ise_pkg::ST_FULL;
              end else begin
                we = 1'b1; waddr = AW'(rc_r); wdata = {e_r, ID_BITS'(1)};
                rc_nxt = rc_r + 1'b1; mc_nxt = mc_r + 1'b1; found_nxt = 1'b1;
              end
            end
          endcase
          state_nxt = S_DONE;
        end
      end
      S_SHR: begin
        // read of idx pending; next cycle write it one slot down (merge) or carry it up (open)
        state_nxt = S_SHW;
      end
      S_SHW: begin
        if (mode_r == 2'd1) begin
          we = 1'b1; waddr = AW'(idx_r - 1'b1); wdata = rdata_r;
          idx_nxt = idx_r + 1'b1; raddr = AW'(idx_r + 1'b1);
          state_nxt = (idx_r + 1'b1 <= rc_r) ? S_SHR : S_DONE;
        end else begin
          // write carried run at idx, keep the one read from idx as carry
          we = 1'b1; waddr = idx_r[AW-1:0]; wdata = carry_r;
          carry_nxt = rdata_r;
          if (idx_r >= rc_r) begin
            rc_nxt = rc_r + 1'b1; state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1; raddr = AW'(idx_r + 1'b1);
            state_nxt = S_SHR;
          end
        end
      end
      S_DONE: begin
        ostb_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; rc_r <= '0; mc_r <= '0; ostb_r <= 1'b0;
    end else begin
      state_r <= state_nxt; rc_r <= rc_nxt; mc_r <= mc_nxt; ostb_r <= ostb_nxt;
    end
    idx_r <= idx_nxt; op_r <= op_nxt; e_r <= e_nxt; pos_r <= pos_nxt;
    acc_r <= acc_nxt; found_r <= found_nxt; ans_r <= ans_nxt; st_r <= st_nxt;
    pv_r <= pv_nxt; ps_r <= ps_nxt; pl_r <= pl_nxt; mode_r <= mode_nxt;
    carry_r <= carry_nxt;
  end

  assign busy = (state_r != S_IDLE) || ostb_r;
  assign out_strobe = ostb_r;
  assign out_word.found = found_r;
  assign out_word.answer = (st_r == ise_pkg::ST_OK) ? ans_r : 32'd0;
  assign out_word.member_total = mc_r;
  assign out_word.run_total = 7'(rc_r);
  assign out_word.status = st_r;
endmodule

// ===== dv/interval_set_checker.sv =====
`timescale 1ns / 100ps
module interval_set_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  ise_pkg::in_word_t  in_word,
  input  logic               out_strobe,
  input  ise_pkg::out_word_t out_word,
  output int                 fail_count,
  output int                 pending
);
  localparam int RUN_SLOTS = ise_pkg::MAX_RUNS_DEF;

  logic [32:0]        set_start[RUN_SLOTS];
  logic [32:0]        set_len[RUN_SLOTS];
  int                 set_runs;
  logic [32:0]        set_members;
  ise_pkg::out_word_t result_q[$];

  assign pending = result_q.size();

  function automatic logic [32:0] last_of(int i);
    return set_start[i] + set_len[i] - 33'd1;
  endfunction

  function automatic bit is_member(logic [32:0] e);
    for (int i = 0; i < set_runs; i++)
      if (set_start[i] <= e && e <= last_of(i)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [2:0] add_entity(logic [32:0] e);
    int i;
    i = 0;
    if (is_member(e)) return ise_pkg::ST_DUP;
    if (set_members >= 33'hFFFF_FFFF) return ise_pkg::ST_FULL;
    while (i < set_runs && e > last_of(i) && e - last_of(i) > 1) i++;
    if (i < set_runs && e < set_start[i] && e + 1 == set_start[i]) begin
      set_start[i] = e;
      set_len[i]++;
    end else if (i < set_runs && e > last_of(i)) begin
      if (i + 1 < set_runs && set_start[i+1] == e + 1) begin
        set_len[i] += set_len[i+1] + 1;
        for (int k = i + 1; k < set_runs - 1; k++) begin
          set_start[k] = set_start[k+1];
          set_len[k]   = set_len[k+1];
        end
        set_runs--;
      end else begin
        set_len[i]++;
      end
    end else begin
      if (set_runs >= RUN_SLOTS) return ise_pkg::ST_FULL;
      for (int k = set_runs; k > i; k--) begin
        set_start[k] = set_start[k-1];
        set_len[k]   = set_len[k-1];
      end
      set_start[i] = e;
      set_len[i]   = 1;
      set_runs++;
    end
    set_members++;
    return ise_pkg::ST_OK;
  endfunction

  function automatic ise_pkg::out_word_t predict_set_op(ise_pkg::in_word_t w);
    ise_pkg::out_word_t r;
    logic [32:0]        e, pos, acc;
    e   = {1'b0, w.entity};
    pos = {1'b0, w.position};
    acc = '0;
    r   = '0;
    case (w.operation)
      ise_pkg::OP_INSERT: begin
        r.status = add_entity(e);
        r.found  = (r.status != ise_pkg::ST_FULL);
      end
      ise_pkg::OP_CONTAINS: r.found = is_member(e);
      ise_pkg::OP_RANK: begin
        r.status = ise_pkg::ST_NOTMEM;
        for (int i = 0; i < set_runs; i++) begin
          if (e <= last_of(i)) begin
            if (e >= set_start[i]) begin
              r.answer = 32'(acc + e - set_start[i]);
              r.found  = 1'b1;
              r.status = ise_pkg::ST_OK;
            end
            break;
          end
          acc += set_len[i];
        end
      end
      default: begin
        r.status = ise_pkg::ST_RANGE;
        for (int i = 0; i < set_runs; i++) begin
          if (pos < set_len[i]) begin
            r.answer = 32'(set_start[i] + pos);
            r.found  = 1'b1;
            r.status = ise_pkg::ST_OK;
            break;
          end
          pos -= set_len[i];
        end
      end
    endcase
    r.member_total = set_members[31:0];
    r.run_total    = 7'(set_runs);
    return r;
  endfunction

  always @(posedge clk) begin
    ise_pkg::out_word_t want;
    if (!rst_n) begin
      set_runs    <= 0;
      set_members <= '0;
      fail_count  <= 0;
      result_q.delete();
    end else begin
      if (out_strobe) begin
        if (result_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result word %h", out_word);
        end else begin
          want = result_q.pop_front();
          if (want !== out_word) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"mismatch: expected found=%0d answer=%h members=%h runs=%0d",
                        " st=%0d, got found=%0d answer=%h members=%h runs=%0d st=%0d"},
                       want.found, want.answer, want.member_total, want.run_total,
                       want.status, out_word.found, out_word.answer,
                       out_word.member_total, out_word.run_total, out_word.status);
          end
        end
      end
      if (start && !busy) result_q = {result_q, predict_set_op(in_word)};
    end
  end
endmodule

// ===== dv/tb_interval_set_engine_core.sv =====
`timescale 1ns / 100ps
module tb_interval_set_engine_core;
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  ise_pkg::in_word_t  in_word = '0;
  logic               out_strobe;
  ise_pkg::out_word_t out_word;
  int                 fail_count;
  int                 pending;
  int                 base_id;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  interval_set_engine_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_word(in_word), .out_strobe(out_strobe), .out_word(out_word)
  );

  interval_set_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_strobe(out_strobe), .out_word(out_word),
    .fail_count(fail_count), .pending(pending)
  );

  // hold the word until accepted, with optional idle burst before it
  task automatic send_word(logic [1:0] op, logic [31:0] ent, logic [31:0] pos,
                           bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= '{operation: op, entity: ent, position: pos};
    do @(posedge clk); while (busy);
  endtask

  // let the checker record the last word before waiting on it
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [1:0]  op;
    logic [31:0] ent;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // empty-set lookups, then extremes and duplicate, extend, bridge and new-run inserts
    send_word(ise_pkg::OP_CONTAINS, 32'h0, 32'h0, 0);
    send_word(ise_pkg::OP_RANK, 32'hFFFF_FFFF, 32'h0, 0);
    send_word(ise_pkg::OP_SELECT, 32'h0, 32'h0, 0);
    send_word(ise_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0, 0);
    send_word(ise_pkg::OP_INSERT, 32'h0, 32'h0, 0);
    send_word(ise_pkg::OP_INSERT, 32'h0, 32'h0, 0);
    send_word(ise_pkg::OP_INSERT, 32'd10, 32'h0, 0);
    send_word(ise_pkg::OP_INSERT, 32'd9, 32'h0, 0);
    send_word(ise_pkg::OP_INSERT, 32'd11, 32'h0, 0);
    send_word(ise_pkg::OP_INSERT, 32'd13, 32'h0, 0);
    send_word(ise_pkg::OP_INSERT, 32'd12, 32'h0, 0);
    send_word(ise_pkg::OP_INSERT, 32'd5, 32'h0, 0);
    send_word(ise_pkg::OP_RANK, 32'd12, 32'h0, 0);
    send_word(ise_pkg::OP_RANK, 32'd7, 32'h0, 0);
    send_word(ise_pkg::OP_RANK, 32'hFFFF_FFFF, 32'h0, 0);
    send_word(ise_pkg::OP_SELECT, 32'h0, 32'd3, 0);
    send_word(ise_pkg::OP_SELECT, 32'h0, 32'd8, 0);
    send_word(ise_pkg::OP_SELECT, 32'h0, 32'hFFFF_FFFF, 0);
    send_word(ise_pkg::OP_CONTAINS, 32'hFFFF_FFFE, 32'h0, 0);
    drain();
    // fill the table with isolated ids to reach the full case
    for (int i = 0; i < 66; i++)
      send_word(ise_pkg::OP_INSERT, 32'h1000 + 4 * i, 32'h0, 1);
    send_word(ise_pkg::OP_SELECT, 32'h0, 32'h5555_AAAA, 0);
    drain();
    // random: mostly ids clustered near a moving base so runs touch and merge
    for (int n = 0; n < 800; n++) begin
      if (n % 200 == 0) base_id = $urandom();
      op  = 2'($urandom_range(0, 3));
      ent = ($urandom_range(0, 9) == 0) ? $urandom()
                                        : base_id + $urandom_range(0, 150);
      send_word(op, ent,
                ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 200),
                n < 700);
      if (n == 400) drain();
    end
    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
